### design/bda_pkg.sv
package bda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int MAX_DIGITS = 10;
  localparam int BCD_W      = MAX_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic shift_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic bits_done;
    logic top_zero;
    logic one_left;
    logic ovf;
  } dp_status_t;

endpackage

### design/bda_in_if.sv
interface bda_in_if;
  logic                         valid;
  logic                         ready;
  logic [bda_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### design/bda_out_if.sv
interface bda_out_if;
  logic                        valid;
  logic                        ready;
  logic [bda_pkg::CHAR_W-1:0]  digit_char;
  logic                        last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

### design/bda_ctrl.sv
module bda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bda_pkg::dp_status_t status,
  output bda_pkg::dp_cmd_t    cmd
);

  bda_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bda_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = bda_pkg::ST_CONV;
      end
      bda_pkg::ST_CONV: begin
        if (status.bits_done) state_nxt = bda_pkg::ST_SKIP;
      end
      bda_pkg::ST_SKIP: begin
        if (!status.top_zero || status.one_left || status.ovf) state_nxt = bda_pkg::ST_EMIT;
      end
      bda_pkg::ST_EMIT: begin
        if (out_ready && status.one_left) state_nxt = bda_pkg::ST_IDLE;
      end
      default: state_nxt = bda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd.load        = 1'b0;
    cmd.conv_step   = 1'b0;
    cmd.shift_digit = 1'b0;
    unique case (state_r)
      bda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bda_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      bda_pkg::ST_SKIP: begin
        // drop leading zeros, keep them all when the value overflowed the buffer
        cmd.shift_digit = status.top_zero && !status.one_left && !status.ovf;
      end
      bda_pkg::ST_EMIT: begin
        out_valid       = 1'b1;
        cmd.shift_digit = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### design/bda_datapath.sv
module bda_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bda_pkg::VALUE_W-1:0] value,
  input  bda_pkg::dp_cmd_t            cmd,
  output bda_pkg::dp_status_t         status,
  output logic [bda_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last
);

  logic [bda_pkg::VALUE_W-1:0]   bin_r, bin_nxt;
  logic [bda_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [bda_pkg::BCD_W-1:0]     bcd_adj;
  logic [bda_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [bda_pkg::DIG_CNT_W-1:0] rem_r, rem_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [3:0]                    top_digit;

  // add-3 correction on every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt     = rem_r;
    ovf_nxt     = ovf_r;
    if (cmd.load) begin
      bin_nxt     = value;
      bcd_nxt     = '0;
      bit_cnt_nxt = bda_pkg::BIT_CNT_W'(bda_pkg::VALUE_W - 1);
      rem_nxt     = bda_pkg::DIG_CNT_W'(bda_pkg::MAX_DIGITS);
      ovf_nxt     = 1'b0;
    end else if (cmd.conv_step) begin
      bin_nxt     = {bin_r[bda_pkg::VALUE_W-2:0], 1'b0};
      bcd_nxt     = {bcd_adj[bda_pkg::BCD_W-2:0], bin_r[bda_pkg::VALUE_W-1]};
      // a bit carried out of the top digit means more digits than the buffer holds
      ovf_nxt     = ovf_r | bcd_adj[bda_pkg::BCD_W-1];
      bit_cnt_nxt = bit_cnt_r - 1'b1;
    end else if (cmd.shift_digit) begin
      bcd_nxt     = {bcd_r[bda_pkg::BCD_W-5:0], 4'd0};
      rem_nxt     = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    ovf_r     <= ovf_nxt;
  end

  assign top_digit        = bcd_r[bda_pkg::BCD_W-1 -: 4];
  assign status.bits_done = (bit_cnt_r == '0);
  assign status.top_zero  = (top_digit == 4'd0);
  assign status.one_left  = (rem_r == bda_pkg::DIG_CNT_W'(1));
  assign status.ovf       = ovf_r;

  assign digit_char = bda_pkg::ASCII_ZERO + {{(bda_pkg::CHAR_W-4){1'b0}}, top_digit};
  assign last       = status.one_left;

endmodule

### design/binary_to_decimal_ascii_top.sv
// binary to decimal ascii converter
// in_ch carries one unsigned 32-bit value per transaction; out_ch returns its
// decimal digits as ascii codes, most significant first, leading zeros
// dropped, with last set on the final digit. zero prints as a single '0'.
// the block works on one value at a time: in_ch.ready is high only while idle.
// order of work per value: accept, a double-dabble shift of each of the 32
// input bits, a scan that drops leading zeros, then one digit per cycle for
// the n digits while out_ch.ready is high.
// the bit-serial shift loop and the one-digit-a-cycle scan set the time per value.
// when out_ch.ready is low the current digit holds on out_ch and the block
// waits; no digit is lost or repeated.
// reset (rst_n low, synchronous) returns the controller to idle and drops any
// value in progress; no state is kept between values.
module binary_to_decimal_ascii_top (
  input  logic      clk,
  input  logic      rst_n,
  bda_in_if.sink    in_ch,
  bda_out_if.source out_ch
);

  bda_pkg::dp_cmd_t    cmd;
  bda_pkg::dp_status_t status;

  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bda_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .value      (in_ch.value),
    .cmd        (cmd),
    .status     (status),
    .digit_char (out_ch.digit_char),
    .last       (out_ch.last)
  );

endmodule

### design/bda_checker.sv
module bda_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bda_pkg::CHAR_W-1:0] digit_char,
  input logic                       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped before transaction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while digits pending");

  a_no_early_digit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("digit or ready right after input transaction");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("run did not end after last digit");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (digit_char >= bda_pkg::CHAR_W'(48)) && (digit_char <= bda_pkg::CHAR_W'(57)))
    else $error("digit code out of range");

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .digit_char (out_ch.digit_char),
  .last       (out_ch.last)
);

### sim/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [bda_pkg::CHAR_W-1:0] digit_char;
  logic                       last;
} digit_xact_t;

class digit_scoreboard;
  digit_xact_t pending_digits[$];
  int          n_values;
  int          n_digits;
  int          errors;

  function new();
    n_values = 0;
    n_digits = 0;
    errors   = 0;
  endfunction

  // expand one accepted value into its expected decimal digits
  function void note_value(logic [bda_pkg::VALUE_W-1:0] value);
    logic [3:0]                 dig [20];
    logic [bda_pkg::VALUE_W-1:0] x;
    int unsigned                lim;
    int unsigned                n;
    digit_xact_t                d;
    lim = bda_pkg::MAX_DIGITS;
    if (lim < 1) lim = 1;
    if (lim > 20) lim = 20;
    x = value;
    n = 0;
    do begin
      dig[n] = 4'(x % 10);
      n++;
      x = x / 10;
    end while (x != 0 && n < lim);
    for (int unsigned k = 0; k < n; k++) begin
      d.digit_char = bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(dig[n - 1 - k]);
      d.last       = (k + 1 == n);
      pending_digits.push_back(d);
    end
    n_values++;
  endfunction

  function void check_digit(logic [bda_pkg::CHAR_W-1:0] digit_char, logic last);
    digit_xact_t want;
    n_digits++;
    if (pending_digits.size() == 0) begin
      $error("unexpected digit transaction: digit_char=%0d last=%0b", digit_char, last);
      errors++;
      return;
    end
    want = pending_digits.pop_front();
    if (digit_char !== want.digit_char) begin
      $error("digit_char mismatch: expected %0d, actual %0d", want.digit_char, digit_char);
      errors++;
    end
    if (last !== want.last) begin
      $error("last mismatch: expected %0b, actual %0b", want.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return pending_digits.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PER_PHASE = 20;

  logic clk;
  logic rst_n;

  bda_in_if  in_ch ();
  bda_out_if out_ch ();

  binary_to_decimal_ascii_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digit_scoreboard digit_sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_left;
  int              cycle_count;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
    digit_sb = new();
  end

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("binary_to_decimal_ascii_top regression: fail");
      $finish;
    end
  end

  // transaction monitors on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) digit_sb.note_value(in_ch.value);
      if (out_ch.valid && out_ch.ready) digit_sb.check_digit(out_ch.digit_char, out_ch.last);
    end
  end

  // receiver pacing, with an optional long hold-off counted here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_value(input logic [bda_pkg::VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.value = $urandom;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.value = value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (digit_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic longint unsigned pow10(int k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [bda_pkg::VALUE_W-1:0] pick_value();
    int              n;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned p;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        // uniform within a random digit count
        n  = $urandom_range(1, 10);
        lo = (n == 1) ? 0 : pow10(n - 1);
        hi = pow10(n) - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(32'(hi), 32'(lo));
      end
      2: begin
        // straddle a power of ten
        p = pow10($urandom_range(0, 9));
        p = p + $urandom_range(2) - 1;
        return 32'(p);
      end
      default: return 32'hFFFF_FFFF - $urandom_range(1000);
    endcase
  endfunction

  logic [bda_pkg::VALUE_W-1:0] directed_values [] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
    32'd100000, 32'd10203040, 32'd999999999, 32'd1000000000,
    32'd1000000001, 32'd1234567890, 32'd2147483647, 32'd2147483648,
    32'd4000000000, 32'd4294967294, 32'd4294967295, 32'hAAAA_AAAA,
    32'h5555_5555, 32'd3000000003, 32'd7
  };

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_values[i]) send_value(directed_values[i]);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // starve the output with a long hold-off while the sender waits with the next value
      if (phase == 0) hold_left = HOLD_CYCLES;
      for (int i = 0; i < RAND_PER_PHASE; i++) send_value(pick_value());
      drain();
    end

    if (digit_sb.pending() != 0) begin
      $error("%0d expected digits never arrived", digit_sb.pending());
      digit_sb.errors++;
    end

    $display("checked %0d values and %0d digit transactions", digit_sb.n_values,
             digit_sb.n_digits);
    $display("pacing: free-running, sender gaps, receiver stalls, mixed, one long hold-off");
    if (digit_sb.errors == 0) begin
      $display("binary_to_decimal_ascii_top regression: pass");
    end else begin
      $display("binary_to_decimal_ascii_top regression: fail");
    end
    $finish;
  end
endmodule
